FILE: hw/rtl/bfws_pkg.sv
// ---------------------------------------------------------------------------
// bfws_pkg: shared types and constants for the box filter window sum core
// Widths, ring and queue sizing, register indexes and the back-end states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfws_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SUM_W       = 22;
  localparam int unsigned RADIUS_W    = 5;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned MAX_RADIUS  = 31;
  localparam int unsigned MAX_LINE    = 4096;
  localparam int unsigned POS_W       = $clog2(MAX_LINE);
  // ring must be deeper than the widest window so read and write never collide
  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned RING_AW     = $clog2(RING_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = LEN_W;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [RADIUS_W-1:0]  RADIUS_RESET   = RADIUS_W'(1);
  localparam logic [POS_W-1:0]     LAST_POS_RESET = POS_W'(63);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = CFG_IDX_W'(1);

  typedef enum logic {
    BK_IDLE,
    BK_FLUSH
  } bk_state_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
    logic [POS_W-1:0]        pos;
  } q_entry_t;

  typedef struct packed {
    logic                re;
    logic [RING_AW-1:0]  addr;
  } ring_rd_t;

  typedef struct packed {
    logic                we;
    logic [RING_AW-1:0]  addr;
    logic [SAMPLE_W-1:0] data;
  } ring_wr_t;

endpackage

FILE: hw/rtl/bfws_ram.sv
// ---------------------------------------------------------------------------
// bfws_ram: generic RAM, one write port, two registered read ports
// Read data updates only when the port's read enable is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rea,
  input  logic [$clog2(DEPTH)-1:0] raddra,
  output logic [WIDTH-1:0]         rdataa,
  input  logic                     reb,
  input  logic [$clog2(DEPTH)-1:0] raddrb,
  output logic [WIDTH-1:0]         rdatab
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rea) begin
      rdataa <= mem[raddra];
    end
    if (reb) begin
      rdatab <= mem[raddrb];
    end
  end

endmodule

FILE: hw/rtl/bfws_queue.sv
// ---------------------------------------------------------------------------
// bfws_queue: short FIFO between the front and back ends
// Head is visible combinationally; count lets the front reserve space.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfws_queue import bfws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  q_entry_t          push_data,
  input  logic              pop,
  output q_entry_t          head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/bfws_front.sv
// ---------------------------------------------------------------------------
// bfws_front: sample intake, ring write and running sum
// Classifies each sample by position, keeps the running window sum and
// queues the sums that produce results. Holds intake during a line flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfws_front import bfws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  flush_done,
  output ring_wr_t              ring_wr,
  output ring_rd_t              ring_rd,
  input  logic [SAMPLE_W-1:0]   ring_rdata,
  output logic                  q_push,
  output q_entry_t              q_push_data,
  input  logic [QCNT_W-1:0]     q_count,
  output logic [RADIUS_W-1:0]   radius
);

  logic [POS_W-1:0]        last_pos;
  logic [POS_W-1:0]        position;
  logic signed [SUM_W-1:0] running_sum;
  logic                    hold;

  // first stage registers
  logic                    valid_d;
  logic [SAMPLE_W-1:0]     x_d;
  logic                    sub_d;
  logic                    emit_d;
  logic                    last_d;
  logic [POS_W-1:0]        pos_d;

  logic                    accept;
  logic                    is_last;
  logic [RADIUS_W:0]       win;
  logic signed [SUM_W-1:0] x_ext;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] sum;
  logic [POS_W-1:0]        len_eff_last;

  assign win     = {radius, 1'b1};
  assign is_last = (position == last_pos);
  assign accept  = s_tvalid && s_tready;

  // space for the item in flight plus the new one
  assign s_tready = !hold &&
    ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_d) < (QCNT_W+1)'(QUEUE_DEPTH));

  always_comb begin
    ring_wr.we   = accept;
    ring_wr.addr = position[RING_AW-1:0];
    ring_wr.data = sample;
    ring_rd.re   = accept;
    ring_rd.addr = position[RING_AW-1:0] - RING_AW'(win);
  end

  assign x_ext   = {{(SUM_W-SAMPLE_W){x_d[SAMPLE_W-1]}}, x_d};
  assign old_ext = {{(SUM_W-SAMPLE_W){ring_rdata[SAMPLE_W-1]}}, ring_rdata};
  assign sum     = running_sum + x_ext - (sub_d ? old_ext : '0);

  assign q_push      = valid_d && (emit_d || last_d);
  assign q_push_data = '{sum: sum, last: last_d, pos: pos_d};

  // zero means one sample, lengths past the maximum clamp
  always_comb begin
    if (cfg_data == '0) begin
      len_eff_last = '0;
    end else if (cfg_data > CFG_DATA_W'(MAX_LINE)) begin
      len_eff_last = POS_W'(MAX_LINE - 1);
    end else begin
      len_eff_last = POS_W'(cfg_data - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_d    <= sample;
      sub_d  <= (position >= POS_W'(win));
      emit_d <= (position >= POS_W'(radius));
      last_d <= is_last;
      pos_d  <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RESET;
      last_pos    <= LAST_POS_RESET;
      position    <= '0;
      running_sum <= '0;
      hold        <= 1'b0;
      valid_d     <= 1'b0;
    end else begin
      valid_d <= accept;
      if (accept) begin
        position <= is_last ? '0 : position + POS_W'(1);
      end
      if (valid_d) begin
        running_sum <= last_d ? '0 : sum;
      end
      if (accept && is_last) begin
        hold <= 1'b1;
      end else if (flush_done) begin
        hold <= 1'b0;
      end
      // a write to the radius or line length register aborts the line in progress
      if (cfg_valid && (cfg_index == CFG_RADIUS || cfg_index == CFG_LINE_LENGTH)) begin
        if (cfg_index == CFG_RADIUS) begin
          radius <= cfg_data[RADIUS_W-1:0];
        end else begin
          last_pos <= len_eff_last;
        end
        position    <= '0;
        running_sum <= '0;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> !s_tready)
    else $error("intake not held after last sample of a line");

endmodule

FILE: hw/rtl/bfws_back.sv
// ---------------------------------------------------------------------------
// bfws_back: result sequencer and output register
// Passes ordinary sums through; on a line's last sum it walks the remaining
// positions, peeling one old sample off the sum per result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfws_back import bfws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [RADIUS_W-1:0]     radius,
  input  logic                    q_empty,
  input  q_entry_t                q_head,
  output logic                    q_pop,
  output ring_rd_t                ring_rd,
  input  logic [SAMPLE_W-1:0]     ring_rdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic signed [SUM_W-1:0] window_sum,
  output logic                    line_end,
  output logic                    flush_done
);

  bk_state_t               state, state_next;
  logic                    out_valid, out_valid_next;
  logic signed [SUM_W-1:0] out_sum, out_sum_next;
  logic                    out_last, out_last_next;
  logic [POS_W-1:0]        q, q_next;
  logic [POS_W-1:0]        p_end, p_end_next;
  logic                    sub_pend, sub_pend_next;

  logic                    out_free;
  logic [POS_W-1:0]        r_pos;
  logic [POS_W-1:0]        q0;
  logic [POS_W-1:0]        q_inc;
  logic signed [SUM_W-1:0] old_ext;

  assign r_pos   = POS_W'(radius);
  assign q0      = (q_head.pos >= r_pos) ? q_head.pos - r_pos : '0;
  assign q_inc   = q + POS_W'(1);
  assign old_ext = {{(SUM_W-SAMPLE_W){ring_rdata[SAMPLE_W-1]}}, ring_rdata};
  assign out_free = !out_valid || m_tready;

  assign m_tvalid   = out_valid;
  assign window_sum = out_sum;
  assign line_end   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_sum  <= out_sum_next;
    out_last <= out_last_next;
    q        <= q_next;
    p_end    <= p_end_next;
    sub_pend <= sub_pend_next;
  end

  // the ring read for position q+1 is issued while q is on the output
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    out_sum_next   = out_sum;
    out_last_next  = out_last;
    q_next         = q;
    p_end_next     = p_end;
    sub_pend_next  = sub_pend;
    q_pop          = 1'b0;
    ring_rd        = '0;
    flush_done     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (out_free) begin
          if (!q_empty) begin
            q_pop          = 1'b1;
            out_valid_next = 1'b1;
            out_sum_next   = q_head.sum;
            out_last_next  = 1'b0;
            if (q_head.last) begin
              q_next        = q0;
              p_end_next    = q_head.pos;
              out_last_next = (q0 == q_head.pos);
              ring_rd.re    = 1'b1;
              ring_rd.addr  = q0[RING_AW-1:0] - RING_AW'(radius);
              sub_pend_next = (q0 >= r_pos);
              if (q0 == q_head.pos) begin
                flush_done = 1'b1;
              end else begin
                state_next = BK_FLUSH;
              end
            end
          end else begin
            out_valid_next = 1'b0;
          end
        end
      end
      BK_FLUSH: begin
        if (m_tready) begin
          q_next        = q_inc;
          out_sum_next  = out_sum - (sub_pend ? old_ext : '0);
          out_last_next = (q_inc == p_end);
          ring_rd.re    = 1'b1;
          ring_rd.addr  = q_inc[RING_AW-1:0] - RING_AW'(radius);
          sub_pend_next = (q_inc >= r_pos);
          if (q_inc == p_end) begin
            flush_done = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  a_flush_has_output: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FLUSH) |-> out_valid)
    else $error("flush running without a result on the output");

  a_done_marks_end: assert property (@(posedge clk) disable iff (rst)
    flush_done |=> (out_valid && out_last))
    else $error("flush done without the line end result");

  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FLUSH) |-> (q < p_end))
    else $error("flush position ran past the line end");

endmodule

FILE: hw/rtl/box_filter_window_sum_core.sv
// ---------------------------------------------------------------------------
// box_filter_window_sum_core: streaming box filter sum along one line
// Exact sliding window sums of 16-bit signed samples, clamped at line ends.
//
// Usage:
//   s_* carries one sample per request; m_* returns one window sum per
//   request, with m_tlast on the result for the last position of a line.
//   cfg_* writes radius (index 0) or line length (index 1); a write resets
//   the line in progress and is only meant while the core is idle.
//   Within a line one sample is taken every cycle unless the output stalls.
//   The result for position p passes the front stage register and the queue
//   into the output register once sample p+radius is taken. The last sample
//   of a line releases the rest, at most radius+1 results, one per cycle while
//   m_tready is high; intake stays closed from that sample until the final
//   result is in the output register; the flush walk reads ring port b.
//   A stalled m_tready holds the output register; the 4-entry queue
//   between the front and back ends then fills and s_tready drops.
//   After rst: radius 1, line length 64, position 0, queue and output empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_window_sum_core import bfws_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,    // [15:0] sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,    // [21:0] window_sum, [23:22] zero
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ring_wr_t                ring_wr;
  ring_rd_t                front_rd;
  ring_rd_t                back_rd;
  logic [SAMPLE_W-1:0]     front_rdata;
  logic [SAMPLE_W-1:0]     back_rdata;
  logic                    q_push;
  q_entry_t                q_push_data;
  logic                    q_pop;
  q_entry_t                q_head;
  logic                    q_empty;
  logic [QCNT_W-1:0]       q_count;
  logic [RADIUS_W-1:0]     radius;
  logic                    flush_done;
  logic signed [SUM_W-1:0] window_sum;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(OUT_TDATA_W-SUM_W){1'b0}}, window_sum};

  bfws_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .sample      (s_tdata[SAMPLE_W-1:0]),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .flush_done  (flush_done),
    .ring_wr     (ring_wr),
    .ring_rd     (front_rd),
    .ring_rdata  (front_rdata),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_count     (q_count),
    .radius      (radius)
  );

  bfws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .we     (ring_wr.we),
    .waddr  (ring_wr.addr),
    .wdata  (ring_wr.data),
    .rea    (front_rd.re),
    .raddra (front_rd.addr),
    .rdataa (front_rdata),
    .reb    (back_rd.re),
    .raddrb (back_rd.addr),
    .rdatab (back_rdata)
  );

  bfws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  bfws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .radius     (radius),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .ring_rd    (back_rd),
    .ring_rdata (back_rdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .window_sum (window_sum),
    .line_end   (m_tlast),
    .flush_done (flush_done)
  );

endmodule

FILE: verif/box_filter_window_sum_core_tb.sv
// ---------------------------------------------------------------------------
// box_filter_window_sum_core_tb: self-checking bench for the window sum core
// Streams lines of signed samples through the core under several radius and
// line length settings and checks each window sum and its line end flag
// against a cycle-free model of the running sum, with random stalls on both
// stream sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_window_sum_core_tb;
  import bfws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  // flush walk plus pipeline, enough for the core to go quiet
  localparam int unsigned SETTLE = MAX_RADIUS + 8;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             line_end;
  } window_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [15:0] sample
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [21:0] window_sum, [23:22] zero
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // window sum model state
  logic signed [SAMPLE_W-1:0] sample_hist [RING_DEPTH];
  int                         line_acc = 0;
  int unsigned                line_pos = 0;
  logic [RADIUS_W-1:0]        radius_reg = RADIUS_W'(1);
  logic [LEN_W-1:0]           length_reg = LEN_W'(64);

  window_result_t pending_sums[$];
  window_result_t want;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int lines_seen = 0;
  int reg_writes = 0;
  int unsigned cycles = 0;

  box_filter_window_sum_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d window sums still expected", $time, pending_sums.size());
      $display("box_filter_window_sum_core_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned line_samples();
    int unsigned n;
    n = length_reg;
    if (n == 0) n = 1;
    if (n > MAX_LINE) n = MAX_LINE;
    return n;
  endfunction

  function automatic void push_sum(int s, logic last);
    window_result_t w;
    w.sum = SUM_W'(s);
    w.line_end = last;
    pending_sums.push_back(w);
  endfunction

  // one accepted sample: update running sum, queue the window sums it releases
  function automatic void predict_window_sums(logic signed [SAMPLE_W-1:0] x);
    int unsigned r, n, p, q;
    int          s;
    r = radius_reg;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    n = line_samples();
    p = line_pos;
    s = line_acc + x;
    if (p >= 2 * r + 1) s -= sample_hist[(p - 2 * r - 1) % RING_DEPTH];
    sample_hist[p % RING_DEPTH] = x;
    if (p + 1 < n) begin
      if (p >= r) push_sum(s, 1'b0);
      line_acc = s;
      line_pos = p + 1;
    end else begin
      // last sample: drain the right-hand windows, shrinking as they go
      for (q = (p >= r) ? p - r : 0; q <= p; q++) begin
        if (q + r > p && q >= r + 1) s -= sample_hist[(q - 1 - r) % RING_DEPTH];
        push_sum(s, q == p);
      end
      line_acc = 0;
      line_pos = 0;
    end
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tlast) lines_seen++;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual sum=%h last=%b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (m_tdata !== {{(OUT_TDATA_W - SUM_W){1'b0}}, want.sum}) begin
          $display("%0t: window_sum mismatch: expected %h actual %h",
                   $time, want.sum, m_tdata);
          errors++;
        end
        if (m_tlast !== want.line_end) begin
          $display("%0t: line_end mismatch: expected %b actual %b",
                   $time, want.line_end, m_tlast);
          errors++;
        end
      end
    end
  end

  // s_tvalid stays high after a request; it only drops on an idle cycle or a stop
  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_window_sums(v);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    if (idx == CFG_RADIUS) begin
      radius_reg = val[RADIUS_W-1:0];
      line_acc = 0;
      line_pos = 0;
    end else if (idx == CFG_LINE_LENGTH) begin
      length_reg = val;
      line_acc = 0;
      line_pos = 0;
    end
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic set_line(input int unsigned r, input int unsigned n);
    wait_idle();
    write_reg(CFG_RADIUS, CFG_DATA_W'(r));
    write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(n));
    end_writes();
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_line(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_sample(rand_sample());
  endtask

  task automatic test_reset_defaults();
    // radius 1, 64 samples per line, no register touched yet; line left open
    send_random_line(6);
  endtask

  task automatic test_sum_extremes();
    // full window of the most negative sample
    set_line(MAX_RADIUS, 63);
    repeat (63) send_sample(16'h8000);
  endtask

  task automatic test_short_lines();
    set_line(0, 0);              // zero length acts as one sample
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h7FFF);
    set_line(5, 1);
    send_sample(16'h8000);
    send_sample(16'h1234);
    set_line(MAX_RADIUS, 3);     // line shorter than the window
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    set_line(2, 5);
    send_random_line(5);
  endtask

  task automatic test_ignored_index();
    set_line(2, 6);
    send_random_line(3);
    wait_idle();
    write_reg(CFG_IDX_W'(15), CFG_DATA_W'(8191));
    write_reg(CFG_IDX_W'(2), CFG_DATA_W'(0));
    end_writes();
    send_random_line(3);         // line carries on where it stopped
  endtask

  task automatic test_abort_line();
    set_line(2, 8);
    send_random_line(3);
    wait_idle();
    write_reg(CFG_RADIUS, CFG_DATA_W'(3));
    end_writes();
    send_random_line(8);
  endtask

  task automatic test_long_line();
    set_line(2, 8191);           // clamps to the longest line; only its start is sent
    send_random_line(6);
  endtask

  task automatic test_random_lines(input int target);
    int          first;
    int unsigned n, lines, pick;
    first = items_sent;
    while (items_sent - first < target) begin
      wait_idle();
      if ($urandom_range(4) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
      if ($urandom_range(2) != 0) begin
        pick = $urandom_range(3);
        write_reg(CFG_RADIUS, CFG_DATA_W'(pick == 0 ? 0 : pick == 1 ? MAX_RADIUS :
                                          $urandom_range(MAX_RADIUS)));
      end
      pick = $urandom_range(9);
      write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(pick == 0 ? 0 : $urandom_range(1, 8)));
      end_writes();
      n = line_samples();
      lines = $urandom_range(1, 2);
      repeat (lines) begin
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(15) == 0) wait_results();
          send_sample(rand_sample());
        end
      end
      // sometimes leave a line unfinished; the next length write drops it
      if (n > 1 && $urandom_range(4) == 0) send_random_line($urandom_range(1, n - 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 22;
    snk_idle_pct = 83;
    test_reset_defaults();
    test_sum_extremes();
    test_short_lines();
    test_ignored_index();
    test_abort_line();
    test_random_lines(5);

    src_idle_pct = 83;
    snk_idle_pct = 22;
    test_random_lines(5);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_lines(5);
    test_long_line();

    wait_idle();
    $display("Covered %0d samples, %0d window sums and %0d finished lines", items_sent,
             results_seen, lines_seen);
    $display("over %0d register writes, radius 0 to 31, lengths 0 to 8191", reg_writes);
    if (errors == 0) begin
      $display("box_filter_window_sum_core_tb: PASS");
    end else begin
      $display("box_filter_window_sum_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bfws_pkg.sv
hw/rtl/bfws_ram.sv
hw/rtl/bfws_queue.sv
hw/rtl/bfws_front.sv
hw/rtl/bfws_back.sv
hw/rtl/box_filter_window_sum_core.sv
verif/box_filter_window_sum_core_tb.sv
